### src/cflts_pkg.sv
// Package: types, constants and float helpers for the CFL local time step block.
package cflts_pkg;

  typedef struct packed {
    logic        first_cell;
    logic [63:0] vel_x;
    logic [63:0] vel_y;
    logic [63:0] vel_z;
    logic [63:0] sound_speed;
    logic [63:0] inverse_volume;
    logic [63:0] area_x_low;
    logic [63:0] area_x_high;
    logic [63:0] area_y_low;
    logic [63:0] area_y_high;
    logic [63:0] area_z_low;
    logic [63:0] area_z_high;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cell_step;
    logic [63:0] sweep_min_step;
    logic [63:0] sweep_max_step;
  } out_item_t;

  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_MUL = 2'd1;
  localparam logic [1:0] FOP_DIV = 2'd2;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } fpu_rsp_t;

  localparam logic [63:0] FP_QNAN   = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] FP_INF    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FP_HALF   = 64'h3FE0_0000_0000_0000;
  localparam logic [63:0] FP_ONE    = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] CFL_RESET = 64'h3FE0_0000_0000_0000;

  function automatic logic fp_is_nan(input logic [63:0] x);
    return x[62:0] > FP_INF[62:0];
  endfunction

  function automatic logic [63:0] fp_canon(input logic [63:0] x);
    return fp_is_nan(x) ? FP_QNAN : x;
  endfunction

  // IEEE less-than: false on NaN, zeros compare equal
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic lt;
    lt = 1'b0;
    if (fp_is_nan(a) || fp_is_nan(b)) begin
      lt = 1'b0;
    end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
      lt = 1'b0;
    end else if (a[63] && !b[63]) begin
      lt = 1'b1;
    end else if (!a[63] && b[63]) begin
      lt = 1'b0;
    end else if (!a[63]) begin
      lt = a[62:0] < b[62:0];
    end else begin
      lt = a[62:0] > b[62:0];
    end
    return lt;
  endfunction

endpackage

### src/cflts_fpu.sv
// Multi-cycle IEEE double add, multiply and divide unit, round to nearest even.
module cflts_fpu (
  input  logic                clk,
  input  logic                rst_n,
  input  cflts_pkg::fpu_req_t req,
  output cflts_pkg::fpu_rsp_t rsp
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_PRE   = 3'd1;
  localparam logic [2:0] F_ALIGN = 3'd2;
  localparam logic [2:0] F_MUL   = 3'd3;
  localparam logic [2:0] F_DIV   = 3'd4;
  localparam logic [2:0] F_NORM  = 3'd5;
  localparam logic [2:0] F_ROUND = 3'd6;
  localparam logic [2:0] F_DONE  = 3'd7;

  logic [2:0]         st_r;
  logic [1:0]         op_r;
  logic               sa_r, sb_r, s_r, eff_sub_r;
  logic signed [13:0] ea_r, eb_r, e_r, cnt_r;
  logic [57:0]        ma_r, mb_r, mw_r;
  logic [105:0]       acc_r;
  logic [53:0]        rem_r;
  logic [63:0]        res_r;

  // special operand handling
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sp;
  logic [63:0] sp_val;

  always_comb begin
    a_nan  = cflts_pkg::fp_is_nan(req.a);
    b_nan  = cflts_pkg::fp_is_nan(req.b);
    a_inf  = req.a[62:0] == cflts_pkg::FP_INF[62:0];
    b_inf  = req.b[62:0] == cflts_pkg::FP_INF[62:0];
    a_zero = req.a[62:0] == 63'd0;
    b_zero = req.b[62:0] == 63'd0;
    sp     = 1'b0;
    sp_val = cflts_pkg::FP_QNAN;
    unique case (req.op)
      cflts_pkg::FOP_ADD: begin
        if (a_nan || b_nan || (a_inf && b_inf && (req.a[63] != req.b[63]))) begin
          sp = 1'b1;
        end else if (a_inf) begin
          sp = 1'b1; sp_val = req.a;
        end else if (b_inf) begin
          sp = 1'b1; sp_val = req.b;
        end else if (a_zero && b_zero) begin
          sp = 1'b1; sp_val = {req.a[63] & req.b[63], 63'd0};
        end else if (a_zero) begin
          sp = 1'b1; sp_val = req.b;
        end else if (b_zero) begin
          sp = 1'b1; sp_val = req.a;
        end
      end
      cflts_pkg::FOP_MUL: begin
        if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
          sp = 1'b1;
        end else if (a_inf || b_inf) begin
          sp = 1'b1; sp_val = {req.a[63] ^ req.b[63], cflts_pkg::FP_INF[62:0]};
        end else if (a_zero || b_zero) begin
          sp = 1'b1; sp_val = {req.a[63] ^ req.b[63], 63'd0};
        end
      end
      cflts_pkg::FOP_DIV: begin
        if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
          sp = 1'b1;
        end else if (a_inf || b_zero) begin
          sp = 1'b1; sp_val = {req.a[63] ^ req.b[63], cflts_pkg::FP_INF[62:0]};
        end else if (a_zero || b_inf) begin
          sp = 1'b1; sp_val = {req.a[63] ^ req.b[63], 63'd0};
        end
      end
      default: sp = 1'b1;
    endcase
  end

  // datapath helpers
  logic        a_big;
  logic [57:0] add_sum;
  logic [53:0] mul_sum;
  logic        div_ge;
  logic [53:0] div_rem;
  logic        rnd_inc;
  logic [53:0] rnd_sum;
  logic signed [13:0] rnd_e;

  always_comb begin
    a_big   = (ea_r > eb_r) || ((ea_r == eb_r) && (ma_r >= mb_r));
    add_sum = eff_sub_r ? (ma_r - mb_r) : (ma_r + mb_r);
    mul_sum = {1'b0, acc_r[105:53]} + (mb_r[0] ? {1'b0, ma_r[52:0]} : 54'd0);
    div_ge  = rem_r >= {1'b0, mb_r[52:0]};
    div_rem = div_ge ? (rem_r - {1'b0, mb_r[52:0]}) : rem_r;
    rnd_inc = mw_r[2] & (mw_r[1] | mw_r[0] | mw_r[3]);
    rnd_sum = {1'b0, mw_r[55:3]} + {53'd0, rnd_inc};
    rnd_e   = rnd_sum[53] ? (e_r + 14'sd1) : e_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            if (sp) begin
              res_r <= sp_val;
              st_r  <= F_DONE;
            end else begin
              sa_r <= req.a[63];
              sb_r <= req.b[63];
              ea_r <= (req.a[62:52] == 11'd0) ? 14'sd1 : $signed({3'd0, req.a[62:52]});
              eb_r <= (req.b[62:52] == 11'd0) ? 14'sd1 : $signed({3'd0, req.b[62:52]});
              ma_r <= {5'd0, req.a[62:52] != 11'd0, req.a[51:0]};
              mb_r <= {5'd0, req.b[62:52] != 11'd0, req.b[51:0]};
              st_r <= F_PRE;
            end
          end
        end
        F_PRE: begin
          if (!ma_r[52]) begin
            ma_r <= {ma_r[56:0], 1'b0};
            ea_r <= ea_r - 14'sd1;
          end
          if (!mb_r[52]) begin
            mb_r <= {mb_r[56:0], 1'b0};
            eb_r <= eb_r - 14'sd1;
          end
          if (ma_r[52] && mb_r[52]) begin
            unique case (op_r)
              cflts_pkg::FOP_ADD: begin
                ma_r      <= a_big ? {ma_r[54:0], 3'd0} : {mb_r[54:0], 3'd0};
                mb_r      <= a_big ? {mb_r[54:0], 3'd0} : {ma_r[54:0], 3'd0};
                e_r       <= a_big ? ea_r : eb_r;
                cnt_r     <= a_big ? (ea_r - eb_r) : (eb_r - ea_r);
                s_r       <= a_big ? sa_r : sb_r;
                eff_sub_r <= sa_r ^ sb_r;
                st_r      <= F_ALIGN;
              end
              cflts_pkg::FOP_MUL: begin
                acc_r <= '0;
                cnt_r <= 14'sd53;
                e_r   <= ea_r + eb_r - 14'sd1023;
                s_r   <= sa_r ^ sb_r;
                st_r  <= F_MUL;
              end
              default: begin
                rem_r <= {1'b0, ma_r[52:0]};
                mw_r  <= '0;
                cnt_r <= 14'sd56;
                e_r   <= ea_r - eb_r + 14'sd1023;
                s_r   <= sa_r ^ sb_r;
                st_r  <= F_DIV;
              end
            endcase
          end
        end
        F_ALIGN: begin
          if (cnt_r == 14'sd0) begin
            if (add_sum == 58'd0) begin
              res_r <= 64'd0;
              st_r  <= F_DONE;
            end else begin
              mw_r <= add_sum;
              st_r <= F_NORM;
            end
          end else if (cnt_r >= 14'sd58) begin
            mb_r  <= {57'd0, |mb_r};
            cnt_r <= 14'sd0;
          end else begin
            mb_r  <= {1'b0, mb_r[57:2], mb_r[1] | mb_r[0]};
            cnt_r <= cnt_r - 14'sd1;
          end
        end
        F_MUL: begin
          if (cnt_r == 14'sd0) begin
            mw_r <= {1'b0, acc_r[105:50], acc_r[49] | (|acc_r[48:0])};
            st_r <= F_NORM;
          end else begin
            acc_r <= {mul_sum, acc_r[52:1]};
            mb_r  <= {1'b0, mb_r[57:1]};
            cnt_r <= cnt_r - 14'sd1;
          end
        end
        F_DIV: begin
          if (cnt_r == 14'sd0) begin
            mw_r <= {mw_r[57:1], mw_r[0] | (|rem_r)};
            st_r <= F_NORM;
          end else begin
            rem_r <= {div_rem[52:0], 1'b0};
            mw_r  <= {mw_r[56:0], div_ge};
            cnt_r <= cnt_r - 14'sd1;
          end
        end
        F_NORM: begin
          if (mw_r[57:56] != 2'd0) begin
            mw_r <= {1'b0, mw_r[57:2], mw_r[1] | mw_r[0]};
            e_r  <= e_r + 14'sd1;
          end else if (e_r < 14'sd1) begin
            if (mw_r[57:1] == 57'd0) begin
              e_r <= 14'sd1;
            end else begin
              mw_r <= {1'b0, mw_r[57:2], mw_r[1] | mw_r[0]};
              e_r  <= e_r + 14'sd1;
            end
          end else if (!mw_r[55] && (e_r > 14'sd1)) begin
            mw_r <= {mw_r[56:0], 1'b0};
            e_r  <= e_r - 14'sd1;
          end else begin
            st_r <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (rnd_e >= 14'sd2047) begin
            res_r <= {s_r, cflts_pkg::FP_INF[62:0]};
          end else if (rnd_sum[53]) begin
            res_r <= {s_r, rnd_e[10:0], 52'd0};
          end else begin
            res_r <= {s_r, rnd_sum[52] ? rnd_e[10:0] : 11'd0, rnd_sum[51:0]};
          end
          st_r <= F_DONE;
        end
        F_DONE: st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done = st_r == F_DONE;
  assign rsp.res  = res_r;

endmodule

### src/cfl_local_time_step_top.sv
// Top level: CFL local time step per cell with running sweep min and max.
// Per cell, 7 divides, 4 multiplies and 6 adds run one after another through the shared
// float unit; not ready for a new cell meanwhile.
// Synchronous active-low reset: idle, cfl_number 0.5, running min and max +0.0.
module cfl_local_time_step_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cflts_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cflts_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          cfg_data
);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_ISSUE = 2'd1;
  localparam logic [1:0] T_WAIT  = 2'd2;
  localparam logic [1:0] T_DONE  = 2'd3;

  localparam logic [1:0] PH_VOL   = 2'd0;
  localparam logic [1:0] PH_AXIS  = 2'd1;
  localparam logic [1:0] PH_SCALE = 2'd2;

  localparam logic [2:0] SB_SUM  = 3'd0;
  localparam logic [2:0] SB_MEAN = 3'd1;
  localparam logic [2:0] SB_LEN  = 3'd2;
  localparam logic [2:0] SB_SPD  = 3'd3;
  localparam logic [2:0] SB_STEP = 3'd4;

  logic [1:0]           st_r, ph_r, ax_r;
  logic [2:0]           sub_r;
  cflts_pkg::in_item_t  item_r;
  cflts_pkg::out_item_t out_r;
  logic                 out_valid_r;
  logic [63:0]          cfl_r, vol_r, len_r, tmp_r, mstep_r, step_r, rmin_r, rmax_r;

  cflts_pkg::fpu_req_t req;
  cflts_pkg::fpu_rsp_t rsp;

  cflts_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  logic [63:0] area_lo, area_hi, vel;

  always_comb begin
    case (ax_r)
      2'd0: begin
        area_lo = item_r.area_x_low; area_hi = item_r.area_x_high; vel = item_r.vel_x;
      end
      2'd1: begin
        area_lo = item_r.area_y_low; area_hi = item_r.area_y_high; vel = item_r.vel_y;
      end
      default: begin
        area_lo = item_r.area_z_low; area_hi = item_r.area_z_high; vel = item_r.vel_z;
      end
    endcase
  end

  always_comb begin
    req.start = st_r == T_ISSUE;
    req.op    = cflts_pkg::FOP_DIV;
    req.a     = cflts_pkg::FP_ONE;
    req.b     = item_r.inverse_volume;
    if (ph_r == PH_SCALE) begin
      req.op = cflts_pkg::FOP_MUL;
      req.a  = mstep_r;
      req.b  = cfl_r;
    end else if (ph_r == PH_AXIS) begin
      unique case (sub_r)
        SB_SUM: begin
          req.op = cflts_pkg::FOP_ADD; req.a = area_lo; req.b = area_hi;
        end
        SB_MEAN: begin
          req.op = cflts_pkg::FOP_MUL; req.a = cflts_pkg::FP_HALF; req.b = tmp_r;
        end
        SB_LEN: begin
          req.op = cflts_pkg::FOP_DIV; req.a = vol_r; req.b = tmp_r;
        end
        SB_SPD: begin
          req.op = cflts_pkg::FOP_ADD; req.a = {1'b0, vel[62:0]};
          req.b  = item_r.sound_speed;
        end
        default: begin
          req.op = cflts_pkg::FOP_DIV; req.a = len_r; req.b = tmp_r;
        end
      endcase
    end
  end

  logic        out_free;
  logic [63:0] rmin_nxt, rmax_nxt;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    rmin_nxt = rmin_r;
    rmax_nxt = rmax_r;
    if (item_r.first_cell) begin
      rmin_nxt = step_r;
      rmax_nxt = step_r;
    end else begin
      if (cflts_pkg::fp_lt(step_r, rmin_r)) rmin_nxt = step_r;
      if (cflts_pkg::fp_lt(rmax_r, step_r)) rmax_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      ph_r        <= PH_VOL;
      ax_r        <= 2'd0;
      sub_r       <= SB_SUM;
      out_valid_r <= 1'b0;
      cfl_r       <= cflts_pkg::CFL_RESET;
      rmin_r      <= 64'd0;
      rmax_r      <= 64'd0;
    end else begin
      if (cfg_valid && cfg_ready) cfl_r <= cfg_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        T_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            ph_r   <= PH_VOL;
            ax_r   <= 2'd0;
            sub_r  <= SB_SUM;
            st_r   <= T_ISSUE;
          end
        end
        T_ISSUE: st_r <= T_WAIT;
        T_WAIT: begin
          if (rsp.done) begin
            st_r <= T_ISSUE;
            if (ph_r == PH_VOL) begin
              vol_r <= rsp.res;
              ph_r  <= PH_AXIS;
            end else if (ph_r == PH_SCALE) begin
              step_r <= cflts_pkg::fp_canon(rsp.res);
              st_r   <= T_DONE;
            end else begin
              if (sub_r == SB_LEN) len_r <= rsp.res;
              else tmp_r <= rsp.res;
              if (sub_r == SB_STEP) begin
                if (ax_r == 2'd0 || cflts_pkg::fp_lt(rsp.res, mstep_r)) mstep_r <= rsp.res;
                sub_r <= SB_SUM;
                if (ax_r == 2'd2) ph_r <= PH_SCALE;
                else ax_r <= ax_r + 2'd1;
              end else begin
                sub_r <= sub_r + 3'd1;
              end
            end
          end
        end
        default: begin
          if (out_free) begin
            rmin_r      <= rmin_nxt;
            rmax_r      <= rmax_nxt;
            out_r       <= '{cell_step: step_r,
                             sweep_min_step: cflts_pkg::fp_canon(rmin_nxt),
                             sweep_max_step: cflts_pkg::fp_canon(rmax_nxt)};
            out_valid_r <= 1'b1;
            st_r        <= T_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready  = st_r == T_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = (st_r == T_IDLE) && !in_valid;

endmodule

### verif/tb_top.sv
// Testbench for the CFL local time step block: random and directed cells, bit-exact predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cflts_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cflts_pkg::out_item_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [63:0]          cfg_data = '0;

  cflts_pkg::in_item_t  pend_cells[$];
  cflts_pkg::out_item_t step_q[$];
  logic [63:0] cfl_val;
  logic [63:0] sweep_min;
  logic [63:0] sweep_max;
  int          in_idle_pct = 14;
  int          out_idle_pct = 65;
  int          errors = 0;
  bit          in_fire = 1'b0;

  cfl_local_time_step_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_nan64(input logic [63:0] x);
    return x[62:0] > cflts_pkg::FP_INF[62:0];
  endfunction

  function automatic bit less64(input logic [63:0] a, input logic [63:0] b);
    bit r;
    r = 1'b0;
    if (!is_nan64(a) && !is_nan64(b) && !(a[62:0] == 0 && b[62:0] == 0)) begin
      if (a[63] != b[63]) r = a[63];
      else if (!a[63]) r = a[62:0] < b[62:0];
      else r = a[62:0] > b[62:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
    return $realtobits($bitstoreal(a) + $bitstoreal(b));
  endfunction

  function automatic logic [63:0] fmul(input logic [63:0] a, input logic [63:0] b);
    return $realtobits($bitstoreal(a) * $bitstoreal(b));
  endfunction

  function automatic logic [63:0] fdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    if (d[62:0] == 0) begin
      if (is_nan64(n) || n[62:0] == 0) r = cflts_pkg::FP_QNAN;
      else r = cflts_pkg::FP_INF | ((n ^ d) & SIGN_MASK);
    end else begin
      r = $realtobits($bitstoreal(n) / $bitstoreal(d));
    end
    return r;
  endfunction

  function automatic logic [63:0] axis_dt(input logic [63:0] vol, input logic [63:0] lo,
                                          input logic [63:0] hi, input logic [63:0] vel,
                                          input logic [63:0] c);
    logic [63:0] len;
    len = fdiv(vol, fmul(cflts_pkg::FP_HALF, fadd(lo, hi)));
    return fdiv(len, fadd({1'b0, vel[62:0]}, c));
  endfunction

  function automatic cflts_pkg::out_item_t predict_step(input cflts_pkg::in_item_t it);
    logic [63:0] vol, sx, sy, sz, m, st;
    cflts_pkg::out_item_t r;
    vol = fdiv(cflts_pkg::FP_ONE, it.inverse_volume);
    sx = axis_dt(vol, it.area_x_low, it.area_x_high, it.vel_x, it.sound_speed);
    sy = axis_dt(vol, it.area_y_low, it.area_y_high, it.vel_y, it.sound_speed);
    sz = axis_dt(vol, it.area_z_low, it.area_z_high, it.vel_z, it.sound_speed);
    m = sx;
    if (less64(sy, m)) m = sy;
    if (less64(sz, m)) m = sz;
    st = fmul(m, cfl_val);
    if (is_nan64(st)) st = cflts_pkg::FP_QNAN;
    if (it.first_cell) begin
      sweep_min = st;
      sweep_max = st;
    end else begin
      if (less64(st, sweep_min)) sweep_min = st;
      if (less64(sweep_max, st)) sweep_max = st;
    end
    r.cell_step = st;
    r.sweep_min_step = sweep_min;
    r.sweep_max_step = sweep_max;
    return r;
  endfunction

  function automatic logic [63:0] rand_dbl();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0: v = {v[63], 63'd0};
      1: v = {v[63], cflts_pkg::FP_INF[62:0]};
      2: v = {v[63], 11'h7FF, (v[51:0] == 0) ? 52'd1 : v[51:0]};
      3: v = {v[63], 11'h000, v[51:0]};
      4: ;
      default: v = {($urandom_range(0, 9) == 0), 11'(1023 - 20 + $urandom_range(0, 40)),
                    v[51:0]};
    endcase
    return v;
  endfunction

  function automatic cflts_pkg::in_item_t rand_cell();
    cflts_pkg::in_item_t c;
    c.first_cell = ($urandom_range(0, 9) == 0);
    c.vel_x = rand_dbl();
    c.vel_y = rand_dbl();
    c.vel_z = rand_dbl();
    c.sound_speed = rand_dbl();
    c.inverse_volume = rand_dbl();
    c.area_x_low = rand_dbl();
    c.area_x_high = rand_dbl();
    c.area_y_low = rand_dbl();
    c.area_y_high = rand_dbl();
    c.area_z_low = rand_dbl();
    c.area_z_high = rand_dbl();
    return c;
  endfunction

  function automatic cflts_pkg::in_item_t uniform_cell(input logic fc, input logic [63:0] v,
                                                       input logic [63:0] c,
                                                       input logic [63:0] iv,
                                                       input logic [63:0] a);
    cflts_pkg::in_item_t r;
    r = '{fc, v, v, v, c, iv, a, a, a, a, a, a};
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      step_q.push_back(predict_step(in_data));
      in_fire = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pend_cells.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_data <= pend_cells.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_fire = 1'b0;
    out_ready <= rst_n && ($urandom_range(0, 99) >= out_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    cflts_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (step_q.size() == 0) begin
        $error("unexpected result transfer %h", out_data);
        errors++;
      end else begin
        e = step_q.pop_front();
        if (out_data.cell_step !== e.cell_step) begin
          $error("cell_step expected %h actual %h", e.cell_step, out_data.cell_step);
          errors++;
        end
        if (out_data.sweep_min_step !== e.sweep_min_step) begin
          $error("sweep_min_step expected %h actual %h", e.sweep_min_step,
                 out_data.sweep_min_step);
          errors++;
        end
        if (out_data.sweep_max_step !== e.sweep_max_step) begin
          $error("sweep_max_step expected %h actual %h", e.sweep_max_step,
                 out_data.sweep_max_step);
          errors++;
        end
      end
    end
  end

  task automatic wait_drain();
    do @(posedge clk);
    while (pend_cells.size() != 0 || in_valid || step_q.size() != 0);
  endtask

  task automatic write_cfl(input logic [63:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfl_val = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [63:0] cfl_settings[6];

  initial begin
    cfl_val = cflts_pkg::CFL_RESET;
    sweep_min = '0;
    sweep_max = '0;
    cfl_settings = '{64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                     64'h3FE6_6666_6666_6666, {$urandom, $urandom}};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // no first cell yet: running values start from +0.0
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b1, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b0, '0, cflts_pkg::FP_ONE, cflts_pkg::FP_HALF,
                                      cflts_pkg::FP_HALF));
    pend_cells.push_back(uniform_cell(1'b0, '1, '1, '1, '1));
    pend_cells.push_back(uniform_cell(1'b1, '0, '0, '0, '0));
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE, '0,
                                      cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, '0));
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_ONE, SIGN_MASK | cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b1, cflts_pkg::FP_INF, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_INF, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b0, cflts_pkg::FP_QNAN, cflts_pkg::FP_ONE,
                                      cflts_pkg::FP_ONE, cflts_pkg::FP_ONE));
    pend_cells.push_back(uniform_cell(1'b0, SIGN_MASK | 64'h4000_0000_0000_0000,
                                      64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
                                      64'h0010_0000_0000_0000));
    pend_cells.push_back(uniform_cell(1'b1, SIGN_MASK, SIGN_MASK, SIGN_MASK, SIGN_MASK));
    pend_cells.push_back('{1'b0, cflts_pkg::FP_ONE, 64'h4000_0000_0000_0000,
                           cflts_pkg::FP_QNAN, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                           cflts_pkg::FP_ONE, cflts_pkg::FP_ONE, cflts_pkg::FP_HALF,
                           cflts_pkg::FP_HALF, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE});
    pend_cells.push_back('{1'b0, cflts_pkg::FP_QNAN, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                           cflts_pkg::FP_ONE, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                           cflts_pkg::FP_ONE, cflts_pkg::FP_ONE, cflts_pkg::FP_ONE,
                           cflts_pkg::FP_ONE, cflts_pkg::FP_ONE});
    wait_drain();

    for (int s = 0; s < 6; s++) begin
      in_idle_pct = (s < 2) ? 14 : (s < 4) ? 65 : 0;
      out_idle_pct = (s < 2) ? 65 : (s < 4) ? 14 : 0;
      write_cfl(cfl_settings[s]);
      for (int k = 0; k < 215; k++) pend_cells.push_back(rand_cell());
      wait_drain();
    end

    repeat (1000) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
